FILE: rtl/core/srt_pkg.sv
`timescale 1ns / 1ps

package srt_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 32;

  localparam logic [2:0] REQ_INSERT     = 3'd0;
  localparam logic [2:0] REQ_DELETE     = 3'd1;
  localparam logic [2:0] REQ_FIND       = 3'd2;
  localparam logic [2:0] REQ_MOD_DATE   = 3'd3;
  localparam logic [2:0] REQ_MOD_SALARY = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic [30:0] key;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    logic [30:0] salary;
  } rec_t;

  typedef struct packed {
    logic [2:0] op;
    rec_t       rec;
  } req_t;

  typedef struct packed {
    logic        strobe;
    logic [1:0]  status;
    logic [4:0]  slot;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    logic [30:0] salary;
    logic [5:0]  entries;
  } resp_t;

  function automatic resp_t make_resp(input logic [1:0] st, input logic [4:0] sl,
                                      input rec_t r, input logic [5:0] ent);
    resp_t o;
    o.strobe  = 1'b1;
    o.status  = st;
    o.slot    = sl;
    o.day     = r.day;
    o.month   = r.month;
    o.year    = r.year;
    o.salary  = r.salary;
    o.entries = ent;
    return o;
  endfunction

endpackage

FILE: rtl/core/srt_ram.sv
`timescale 1ns / 1ps

module srt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/srt_ctrl.sv
`timescale 1ns / 1ps

module srt_ctrl #(
  parameter int TABLE_DEPTH = srt_pkg::TABLE_DEPTH_DEFAULT,
  localparam int IW = $clog2(TABLE_DEPTH),
  localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  srt_pkg::req_t  req_in,
  output logic           busy,
  output srt_pkg::resp_t resp,
  output logic [IW-1:0]  rd_addr,
  input  srt_pkg::rec_t  rd_data,
  output logic           we,
  output logic [IW-1:0]  wr_addr,
  output srt_pkg::rec_t  wr_data
);

  import srt_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_DECIDE = 6'b000100,
    S_SHUP   = 6'b001000,
    S_SHDN   = 6'b010000,
    S_WRITE  = 6'b100000
  } state_t;

  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] ONE     = CW'(1);
  localparam logic [CW-1:0] TWO     = CW'(2);

  state_t        state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [CW-1:0] pos, pos_next;
  logic [CW-1:0] idx, idx_next;
  logic          found, found_next;
  req_t          req, req_next;
  rec_t          hit, hit_next;
  rec_t          wrec, wrec_next;
  resp_t         resp_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    pos_next   = pos;
    idx_next   = idx;
    found_next = found;
    req_next   = req;
    hit_next   = hit;
    wrec_next  = wrec;
    resp_next  = '0;
    rd_addr    = '0;
    we         = 1'b0;
    wr_addr    = pos[IW-1:0];
    wr_data    = wrec;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          req_next = req_in;
          if (req_in.op > REQ_MOD_SALARY) begin
            resp_next = make_resp(ST_OK, 5'd0, '0, 6'(cnt));
          end else if (cnt == '0) begin
            found_next = 1'b0;
            pos_next   = '0;
            state_next = S_DECIDE;
          end else begin
            idx_next   = '0;
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        rd_addr = IW'(idx + ONE);
        if (rd_data.key >= req.rec.key) begin
          found_next = (rd_data.key == req.rec.key);
          pos_next   = idx;
          hit_next   = rd_data;
          state_next = S_DECIDE;
        end else if (idx + ONE == cnt) begin
          found_next = 1'b0;
          pos_next   = cnt;
          state_next = S_DECIDE;
        end else begin
          idx_next = idx + ONE;
        end
      end
      S_DECIDE: begin
        state_next = S_IDLE;
        unique case (req.op) inside
          REQ_INSERT: begin
            if (found) begin
              resp_next = make_resp(ST_DUP, 5'(pos), hit, 6'(cnt));
            end else if (cnt == DEPTH_C) begin
              resp_next = make_resp(ST_FULL, 5'd0, '0, 6'(cnt));
            end else begin
              wrec_next = req.rec;
              if (pos == cnt) begin
                state_next = S_WRITE;
              end else begin
                idx_next   = cnt;
                rd_addr    = IW'(cnt - ONE);
                state_next = S_SHUP;
              end
            end
          end
          REQ_DELETE: begin
            if (!found) begin
              resp_next = make_resp(ST_MISS, 5'd0, '0, 6'(cnt));
            end else if (pos + ONE == cnt) begin
              cnt_next  = cnt - ONE;
              resp_next = make_resp(ST_OK, 5'(pos), hit, 6'(cnt - ONE));
            end else begin
              idx_next   = pos;
              rd_addr    = IW'(pos + ONE);
              state_next = S_SHDN;
            end
          end
          REQ_FIND: begin
            if (!found) begin
              resp_next = make_resp(ST_MISS, 5'd0, '0, 6'(cnt));
            end else begin
              resp_next = make_resp(ST_OK, 5'(pos), hit, 6'(cnt));
            end
          end
          REQ_MOD_DATE, REQ_MOD_SALARY: begin
            if (!found) begin
              resp_next = make_resp(ST_MISS, 5'd0, '0, 6'(cnt));
            end else begin
              wrec_next = hit;
              if (req.op == REQ_MOD_DATE) begin
                wrec_next.day   = req.rec.day;
                wrec_next.month = req.rec.month;
                wrec_next.year  = req.rec.year;
              end else begin
                wrec_next.salary = req.rec.salary;
              end
              state_next = S_WRITE;
            end
          end
          default: begin
            resp_next = make_resp(ST_OK, 5'd0, '0, 6'(cnt));
          end
        endcase
      end
      S_SHUP: begin
        we      = 1'b1;
        wr_addr = idx[IW-1:0];
        wr_data = rd_data;
        rd_addr = IW'(idx - TWO);
        if (idx - ONE == pos) begin
          state_next = S_WRITE;
        end else begin
          idx_next = idx - ONE;
        end
      end
      S_SHDN: begin
        we      = 1'b1;
        wr_addr = idx[IW-1:0];
        wr_data = rd_data;
        rd_addr = IW'(idx + TWO);
        if (idx + TWO == cnt) begin
          cnt_next   = cnt - ONE;
          resp_next  = make_resp(ST_OK, 5'(pos), hit, 6'(cnt - ONE));
          state_next = S_IDLE;
        end else begin
          idx_next = idx + ONE;
        end
      end
      S_WRITE: begin
        we      = 1'b1;
        wr_addr = pos[IW-1:0];
        wr_data = wrec;
        if (req.op == REQ_INSERT) begin
          cnt_next  = cnt + ONE;
          resp_next = make_resp(ST_OK, 5'(pos), wrec, 6'(cnt + ONE));
        end else begin
          resp_next = make_resp(ST_OK, 5'(pos), wrec, 6'(cnt));
        end
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      resp  <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      resp  <= resp_next;
    end
  end

  always_ff @(posedge clk) begin
    pos   <= pos_next;
    idx   <= idx_next;
    found <= found_next;
    req   <= req_next;
    hit   <= hit_next;
    wrec  <= wrec_next;
  end

endmodule

FILE: rtl/core/sorted_record_table_unit.sv
// Record table kept in ascending key order in one memory with a registered read port.
// A request is taken at a clock edge where start is high and busy is low; its result
// shows on the result ports for exactly one cycle with done high, and the receiver
// cannot stall it, so it must be taken then. A request of a used type on a non-empty
// table first walks the table from slot 0, one memory read per cycle, until it meets
// a key not below the requested one; on an empty table it goes straight to its
// decision. An insert of a new key into a table with room then moves the records
// from the slot where the walk stopped up one slot each and writes the new record,
// a delete of a found key moves the records above that slot down one slot each, and
// a modify of a found key writes the record once. The worst case is an insert at
// slot 0 of a nearly full table. Unused request types are answered in the cycle after
// the transfer. busy drops in the cycle done is high, so the next request may follow.
`timescale 1ns / 1ps

module sorted_record_table_unit #(
  parameter int TABLE_DEPTH = srt_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [2:0]  req_type,
  input  logic [30:0] key,
  input  logic [4:0]  in_day,
  input  logic [3:0]  in_month,
  input  logic [11:0] in_year,
  input  logic [30:0] in_salary,
  output logic        busy,
  output logic        done,
  output logic [1:0]  status,
  output logic [4:0]  slot,
  output logic [4:0]  out_day,
  output logic [3:0]  out_month,
  output logic [11:0] out_year,
  output logic [30:0] out_salary,
  output logic [5:0]  entries
);

  import srt_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);

  req_t          req_in;
  resp_t         resp;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] wr_addr;
  logic          we;
  rec_t          rd_data;
  rec_t          wr_data;

  always_comb begin
    req_in.op         = req_type;
    req_in.rec.key    = key;
    req_in.rec.day    = in_day;
    req_in.rec.month  = in_month;
    req_in.rec.year   = in_year;
    req_in.rec.salary = in_salary;
  end

  srt_ram #(
    .WIDTH($bits(rec_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(wr_addr),
    .wdata(wr_data),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  srt_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .req_in (req_in),
    .busy   (busy),
    .resp   (resp),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .we     (we),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  assign done       = resp.strobe;
  assign status     = resp.status;
  assign slot       = resp.slot;
  assign out_day    = resp.day;
  assign out_month  = resp.month;
  assign out_year   = resp.year;
  assign out_salary = resp.salary;
  assign entries    = resp.entries;

endmodule

FILE: rtl/core/srt_chk.sv
`timescale 1ns / 1ps

module srt_chk #(
  parameter int TABLE_DEPTH = srt_pkg::TABLE_DEPTH_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic [2:0]  req_type,
  input logic        busy,
  input logic        done,
  input logic [1:0]  status,
  input logic [4:0]  slot,
  input logic [4:0]  out_day,
  input logic [3:0]  out_month,
  input logic [11:0] out_year,
  input logic [30:0] out_salary,
  input logic [5:0]  entries
);

  import srt_pkg::*;

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !busy && !done)
    else $error("busy or done right after reset");

  a_unused_req: assert property (@(posedge clk) disable iff (rst)
    start && !busy && req_type > REQ_MOD_SALARY |=> done && !busy && status == ST_OK &&
      slot == 5'd0)
    else $error("unused request type not answered at once");

  a_real_req_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && req_type <= REQ_MOD_SALARY |=> busy && !done)
    else $error("request transfer did not start work");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_FULL |-> entries == 6'(TABLE_DEPTH))
    else $error("full status with table not full");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_MISS || status == ST_FULL) |-> slot == 5'd0 && out_day == 5'd0 &&
      out_month == 4'd0 && out_year == 12'd0 && out_salary == 31'd0)
    else $error("refused request reports record fields");

endmodule

bind sorted_record_table_unit srt_chk #(.TABLE_DEPTH(TABLE_DEPTH)) u_chk (.*);
